// ===== rtl/hop_pkg.sv =====
// shared constants and types for the on/off haptic pattern player
`timescale 1ns / 1ps

package hop_pkg;

  // pattern table depth and duration width
  localparam int PatternDepth = 16;
  localparam int DurationBits = 16;

  // derived widths, with fixed count and index widths
  localparam int AddrBits  = (PatternDepth > 1) ? $clog2(PatternDepth) : 1;
  localparam int LenBits   = $clog2(PatternDepth + 1);
  localparam int CountBits = 5;
  localparam int IndexBits = 4;

  // configuration register indexes
  localparam logic CfgOnLevel  = 1'b0;
  localparam logic CfgOffLevel = 1'b1;

  // item modes
  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_START = 2'd2,
    MODE_STOP  = 2'd3
  } mode_t;

endpackage

// ===== rtl/haptic_on_off_pattern_player.sv =====
// top level of the on/off haptic pattern player
`timescale 1ns / 1ps

// Plays a table of (on-time, off-time) pairs on a motor pin, one input
// transaction per clock cycle when the output side does not stall. Each
// transaction gives exactly one result transaction. An item is written to or
// read from the two duration memories in the cycle it is accepted; the
// following cycle the read data and the playback state meet in the update
// stage, and the result lands in the output register when the item leaves
// it. The read address for a tick is forwarded from the state the update
// stage is about to store, so items follow back to back.
// The table has no reset: an entry must be written before playback reads it.
module haptic_on_off_pattern_player (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write port
  input  logic                           cfg_write,
  input  logic                           cfg_index,
  input  logic                           cfg_data,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     mode,
  input  logic [hop_pkg::IndexBits-1:0]  element_index,
  input  logic [15:0]                    on_duration_ms,
  input  logic [15:0]                    off_duration_ms,
  input  logic [hop_pkg::CountBits-1:0]  element_count,
  // output channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           motor_pin,
  output logic                           playing,
  output logic                           status
);

  localparam int DW = hop_pkg::DurationBits;
  localparam int AW = hop_pkg::AddrBits;
  localparam int LW = hop_pkg::LenBits;

  // configuration registers
  logic on_level;
  logic off_level;

  // duration memories
  logic [DW-1:0] on_mem  [hop_pkg::PatternDepth];
  logic [DW-1:0] off_mem [hop_pkg::PatternDepth];
  logic [DW-1:0] on_rd;
  logic [DW-1:0] off_rd;

  // update stage item
  logic                          p_valid;
  hop_pkg::mode_t                p_mode;
  logic [hop_pkg::CountBits-1:0] p_count;

  // playback state
  logic [LW-1:0] finished_elements, finished_elements_next;
  logic [LW-1:0] started_elements, started_elements_next;
  logic [LW-1:0] pattern_length, pattern_length_next;
  logic [DW-1:0] remaining_ms, remaining_ms_next;
  logic          running, running_next;
  logic          motor_driven, motor_driven_next;
  logic          status_next;

  logic          advance;
  logic          accept;
  hop_pkg::mode_t in_mode;
  logic [AW-1:0] rd_addr;
  logic [DW-1:0] rem_dec;

  assign in_mode  = hop_pkg::mode_t'(mode);
  assign advance  = p_valid && (!out_valid || !out_stall);
  assign in_stall = p_valid && !advance;
  assign accept   = in_valid && !in_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      on_level  <= 1'b1;
      off_level <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        hop_pkg::CfgOnLevel:  on_level  <= cfg_data;
        hop_pkg::CfgOffLevel: off_level <= cfg_data;
        default: ;
      endcase
    end
  end

  // read address: element 0 for a start, else the forwarded finished count
  always_comb begin
    if (in_mode == hop_pkg::MODE_START) begin
      rd_addr = '0;
    end else begin
      rd_addr = finished_elements_next[AW-1:0];
    end
  end

  // memory write and registered read at acceptance
  always_ff @(posedge clk) begin
    if (accept) begin
      if (in_mode == hop_pkg::MODE_WRITE) begin
        if (int'(element_index) < hop_pkg::PatternDepth) begin
          on_mem[element_index[AW-1:0]]  <= on_duration_ms[DW-1:0];
          off_mem[element_index[AW-1:0]] <= off_duration_ms[DW-1:0];
        end
      end else begin
        on_rd  <= on_mem[rd_addr];
        off_rd <= off_mem[rd_addr];
      end
    end
  end

  // update stage occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (accept) begin
      p_valid <= 1'b1;
    end else if (advance) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_mode  <= in_mode;
      p_count <= element_count;
    end
  end

  // playback state update
  always_comb begin
    finished_elements_next = finished_elements;
    started_elements_next  = started_elements;
    pattern_length_next    = pattern_length;
    remaining_ms_next      = remaining_ms;
    running_next           = running;
    motor_driven_next      = motor_driven;
    status_next            = 1'b0;
    rem_dec                = (remaining_ms != '0) ? remaining_ms - DW'(1) : '0;
    if (advance) begin
      unique case (p_mode)
        hop_pkg::MODE_TICK: begin
          if (running) begin
            remaining_ms_next = rem_dec;
            if (rem_dec == '0) begin
              if (finished_elements >= pattern_length) begin
                running_next      = 1'b0;
                motor_driven_next = 1'b0;
              end else if (finished_elements < started_elements) begin
                remaining_ms_next      = (off_rd == '0) ? DW'(1) : off_rd;
                finished_elements_next = finished_elements + LW'(1);
                motor_driven_next      = 1'b0;
              end else begin
                remaining_ms_next     = (on_rd == '0) ? DW'(1) : on_rd;
                started_elements_next = started_elements + LW'(1);
                motor_driven_next     = 1'b1;
              end
            end
          end
        end
        hop_pkg::MODE_WRITE: ;
        hop_pkg::MODE_START: begin
          if (p_count == '0) begin
            status_next = 1'b1;
          end else begin
            running_next           = 1'b0;
            motor_driven_next      = 1'b0;
            finished_elements_next = '0;
            started_elements_next  = '0;
            if (int'(p_count) > hop_pkg::PatternDepth) begin
              pattern_length_next = LW'(hop_pkg::PatternDepth);
            end else begin
              pattern_length_next = LW'(p_count);
            end
            if (on_rd != '0) begin
              remaining_ms_next     = on_rd;
              started_elements_next = LW'(1);
              motor_driven_next     = 1'b1;
              running_next          = 1'b1;
            end
          end
        end
        hop_pkg::MODE_STOP: begin
          running_next      = 1'b0;
          motor_driven_next = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      finished_elements <= '0;
      started_elements  <= '0;
      pattern_length    <= '0;
      remaining_ms      <= '0;
      running           <= 1'b0;
      motor_driven      <= 1'b0;
    end else begin
      finished_elements <= finished_elements_next;
      started_elements  <= started_elements_next;
      pattern_length    <= pattern_length_next;
      remaining_ms      <= remaining_ms_next;
      running           <= running_next;
      motor_driven      <= motor_driven_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      motor_pin <= motor_driven_next ? on_level : off_level;
      playing   <= running_next;
      status    <= status_next;
    end
  end

endmodule

// ===== verif/tb_haptic_on_off_pattern_player.sv =====
// self-checking testbench for the on/off haptic pattern player
`timescale 1ns / 1ps

module tb_haptic_on_off_pattern_player;
  import hop_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PER_PHASE = 475;
  localparam int DRAIN_CYCLES = 8;

  // one expected result transaction
  typedef struct packed {
    logic pin;
    logic run;
    logic rej;
  } pin_state_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic                 cfg_index = 1'b0;
  logic                 cfg_data = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           mode = MODE_TICK;
  logic [IndexBits-1:0] element_index = '0;
  logic [15:0]          on_duration_ms = '0;
  logic [15:0]          off_duration_ms = '0;
  logic [CountBits-1:0] element_count = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 motor_pin;
  logic                 playing;
  logic                 status;

  haptic_on_off_pattern_player u_top (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .mode            (mode),
    .element_index   (element_index),
    .on_duration_ms  (on_duration_ms),
    .off_duration_ms (off_duration_ms),
    .element_count   (element_count),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .motor_pin       (motor_pin),
    .playing         (playing),
    .status          (status)
  );

  // player state as the testbench sees it
  logic [15:0] tbl_on_ms [PatternDepth];
  logic [15:0] tbl_off_ms [PatternDepth];
  int          done_elems = 0;
  int          begun_elems = 0;
  int          play_len = 0;
  logic [15:0] ms_left = '0;
  bit          timer_run = 1'b0;
  bit          motor_on = 1'b0;
  bit          lvl_on = 1'b1;
  bit          lvl_off = 1'b0;

  pin_state_t  pin_state_due [$];
  pin_state_t  want;
  int          fails = 0;
  int          quiet_cycles = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // load the next phase once the countdown runs out
  function automatic void advance_phase();
    if (done_elems >= play_len) begin
      timer_run = 1'b0;
      motor_on = 1'b0;
    end else if (done_elems < begun_elems) begin
      ms_left = (tbl_off_ms[done_elems] == 0) ? 16'd1 : tbl_off_ms[done_elems];
      done_elems++;
      motor_on = 1'b0;
      timer_run = 1'b1;
    end else begin
      ms_left = (tbl_on_ms[done_elems] == 0) ? 16'd1 : tbl_on_ms[done_elems];
      begun_elems++;
      motor_on = 1'b1;
      timer_run = 1'b1;
    end
  endfunction

  // work out the pin state that one accepted item leads to
  function automatic void predict_pin_state(mode_t m, logic [IndexBits-1:0] idx,
                                            logic [15:0] on_ms, logic [15:0] off_ms,
                                            logic [CountBits-1:0] cnt);
    pin_state_t res;
    int         len;
    res.rej = 1'b0;
    case (m)
      MODE_TICK: begin
        if (timer_run) begin
          if (ms_left > 0) ms_left--;
          if (ms_left == 0) advance_phase();
        end
      end
      MODE_WRITE: begin
        tbl_on_ms[idx] = on_ms;
        tbl_off_ms[idx] = off_ms;
      end
      MODE_START: begin
        if (cnt == 0) begin
          res.rej = 1'b1;
        end else begin
          timer_run = 1'b0;
          motor_on = 1'b0;
          len = (cnt > PatternDepth) ? PatternDepth : int'(cnt);
          play_len = len;
          done_elems = 0;
          begun_elems = 0;
          if (tbl_on_ms[0] != 0) begin
            ms_left = tbl_on_ms[0];
            begun_elems = 1;
            motor_on = 1'b1;
            timer_run = 1'b1;
          end
        end
      end
      default: begin
        timer_run = 1'b0;
        motor_on = 1'b0;
      end
    endcase
    res.pin = motor_on ? lvl_on : lvl_off;
    res.run = timer_run;
    pin_state_due.push_back(res);
  endfunction

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pin_state_due.size() == 0) begin
        $error("result transaction with nothing expected");
        fails++;
      end else begin
        want = pin_state_due.pop_front();
        if (motor_pin !== want.pin) begin
          $error("motor_pin: expected %0b, got %0b", want.pin, motor_pin);
          fails++;
        end
        if (playing !== want.run) begin
          $error("playing: expected %0b, got %0b", want.run, playing);
          fails++;
        end
        if (status !== want.rej) begin
          $error("status: expected %0b, got %0b", want.rej, status);
          fails++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // offer one item, wait for the transaction, then predict its result
  task automatic send_item(mode_t m, logic [IndexBits-1:0] idx, logic [15:0] on_ms,
                           logic [15:0] off_ms, logic [CountBits-1:0] cnt);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    element_index <= idx;
    on_duration_ms <= on_ms;
    off_duration_ms <= off_ms;
    element_count <= cnt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_pin_state(m, idx, on_ms, off_ms, cnt);
  endtask

  // wait for every outstanding result
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pin_state_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // program both pin levels while the block is idle
  task automatic set_levels(bit on_lvl, bit off_lvl);
    drain_results();
    cfg_write <= 1'b1;
    cfg_index <= CfgOnLevel;
    cfg_data <= on_lvl;
    @(posedge clk);
    cfg_index <= CfgOffLevel;
    cfg_data <= off_lvl;
    @(posedge clk);
    cfg_write <= 1'b0;
    lvl_on = on_lvl;
    lvl_off = off_lvl;
  endtask

  // every table entry is written before any playback reads it
  task automatic test_table_load();
    for (int i = 0; i < PatternDepth; i++) begin
      if (i == 0) send_item(MODE_WRITE, 4'(i), 16'd2, 16'd0, 5'd0);
      else if (i == 1) send_item(MODE_WRITE, 4'(i), 16'd0, 16'd1, 5'd0);
      else if (i == 14) send_item(MODE_WRITE, 4'(i), 16'h5555, 16'hAAAA, 5'd31);
      else if (i == 15) send_item(MODE_WRITE, 4'(i), 16'hFFFF, 16'hFFFF, 5'd16);
      else send_item(MODE_WRITE, 4'(i), 16'($urandom_range(3)),
                     16'($urandom_range(3)), 5'd0);
    end
  endtask

  // rejection, idle items, a full short pattern, saturation, rewrite, dormant start
  task automatic test_directed_cases();
    send_item(MODE_START, 4'd0, 16'd0, 16'd0, 5'd0);
    send_item(MODE_TICK, 4'd0, 16'd0, 16'd0, 5'd0);
    send_item(MODE_STOP, 4'd0, 16'd0, 16'd0, 5'd0);
    // two elements with zero durations played as one ms, through to the end
    send_item(MODE_START, 4'd15, 16'hFFFF, 16'hFFFF, 5'd2);
    repeat (6) send_item(MODE_TICK, 4'd0, 16'd0, 16'd0, 5'd0);
    // length above depth, entry rewritten while playing, stop mid-pattern
    send_item(MODE_START, 4'd0, 16'd0, 16'd0, 5'd31);
    send_item(MODE_TICK, 4'd0, 16'd0, 16'd0, 5'd0);
    send_item(MODE_WRITE, 4'd1, 16'd5, 16'd3, 5'd0);
    repeat (3) send_item(MODE_TICK, 4'd0, 16'd0, 16'd0, 5'd0);
    send_item(MODE_STOP, 4'd0, 16'd0, 16'd0, 5'd0);
    send_item(MODE_TICK, 4'd0, 16'd0, 16'd0, 5'd0);
    // zero first on-time leaves the pattern dormant
    send_item(MODE_WRITE, 4'd0, 16'd0, 16'd2, 5'd0);
    send_item(MODE_START, 4'd0, 16'd0, 16'd0, 5'd1);
    send_item(MODE_TICK, 4'd0, 16'd0, 16'd0, 5'd0);
    send_item(MODE_WRITE, 4'd0, 16'd2, 16'd0, 5'd0);
  endtask

  // mostly ticks so patterns play deep, with writes, restarts and stops
  task automatic test_random_traffic(int idle, int stall, bit on_lvl, bit off_lvl);
    int          pick;
    int          r;
    mode_t       m;
    logic [15:0] on_ms;
    logic [15:0] off_ms;
    logic [4:0]  cnt;
    set_levels(on_lvl, off_lvl);
    idle_pct = idle;
    stall_pct = stall;
    for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
      pick = $urandom_range(99);
      if (pick < 68) m = MODE_TICK;
      else if (pick < 80) m = MODE_WRITE;
      else if (pick < 93) m = MODE_START;
      else m = MODE_STOP;
      on_ms = ($urandom_range(49) == 0) ? 16'($urandom) : 16'($urandom_range(4));
      off_ms = ($urandom_range(49) == 0) ? 16'($urandom) : 16'($urandom_range(4));
      r = $urandom_range(99);
      if (r < 5) cnt = 5'd0;
      else if (r < 15) cnt = 5'($urandom_range(31, 17));
      else cnt = 5'($urandom_range(16, 1));
      send_item(m, 4'($urandom_range(15)), on_ms, off_ms, cnt);
    end
    idle_pct = 0;
    stall_pct = 0;
  endtask

  // test sequence
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_table_load();
    test_directed_cases();
    test_random_traffic(0, 0, 1'b0, 1'b1);
    test_random_traffic(87, 0, 1'b1, 1'b1);
    test_random_traffic(0, 87, 1'b0, 1'b0);
    test_random_traffic(31, 31, 1'b1, 1'b0);
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/hop_pkg.sv
rtl/haptic_on_off_pattern_player.sv
verif/tb_haptic_on_off_pattern_player.sv
